FILE: hdl/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Shared widths, codes, pipeline types and the sigmoid breakpoint table for
// the activation forward/backward unit.
// ----------------------------------------------------------------------------
package afb_pkg;

  localparam int DATA_W    = 16;   // Q4.12 operand and result width
  localparam int IDX_W     = 12;   // element index width
  localparam int KIND_W    = 2;
  localparam int IDX_CMP_W = 17;   // wide enough to hold the largest element count

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam int MAX_ELEMENTS_DEF = 4096;

  // sigmoid table over the full 16-bit input range
  localparam int TABLE_SEGMENTS = 64;
  localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
  localparam int OFS_BITS       = DATA_W - SEG_BITS;
  localparam int ROM_W          = FRAC_BITS;

  // gradient datapath widths
  localparam int P1_W = 2 * DATA_W + 1;          // activation times (one - activation), or times itself
  localparam int D_W  = P1_W - FRAC_BITS;        // derivative
  localparam int P2_W = DATA_W + D_W;            // gradient times derivative

  localparam logic [KIND_W-1:0] KIND_RELU    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGMOID = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TANH    = 2'd2;

  localparam logic CMD_FORWARD  = 1'b0;
  localparam logic CMD_BACKWARD = 1'b1;

  // sigmoid at x = -8.0, -7.75, ... , +8.0 as unsigned Q0.12 fractions
  localparam logic [ROM_W-1:0] SIG_ROM [0:TABLE_SEGMENTS] = '{
    12'd1,    12'd2,    12'd2,    12'd3,    12'd4,    12'd5,    12'd6,    12'd8,
    12'd10,   12'd13,   12'd17,   12'd21,   12'd27,   12'd35,   12'd45,   12'd58,
    12'd74,   12'd94,   12'd120,  12'd153,  12'd194,  12'd246,  12'd311,  12'd391,
    12'd488,  12'd606,  12'd747,  12'd912,  12'd1102, 12'd1314, 12'd1546, 12'd1793,
    12'd2048, 12'd2303, 12'd2550, 12'd2782, 12'd2994, 12'd3184, 12'd3349, 12'd3490,
    12'd3608, 12'd3705, 12'd3785, 12'd3850, 12'd3902, 12'd3943, 12'd3976, 12'd4002,
    12'd4022, 12'd4038, 12'd4051, 12'd4061, 12'd4069, 12'd4075, 12'd4079, 12'd4083,
    12'd4086, 12'd4088, 12'd4090, 12'd4091, 12'd4092, 12'd4093, 12'd4094, 12'd4094,
    12'd4095
  };

  typedef struct packed {
    logic                     cmd;
    logic                     in_range;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] operand;
  } afb_tag_t;

  // load enables of the pipeline registers, stage 2 through the output stage
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic o;
  } afb_en_t;

endpackage

FILE: hdl/activation_forward_backward_unit_top.sv
// ----------------------------------------------------------------------------
// activation_forward_backward_unit_top
// A 7-register pipeline runs from request acceptance to out_valid.
// Throughput: one request per cycle; an output stall holds each full stage,
// empty stages still fill.
// The store is written and read in stage 3, so back-to-back forward/backward
// requests on one index need no hazard logic.
// Reset clears all valid bits and activation_kind; the store is not cleared.
// ----------------------------------------------------------------------------
module activation_forward_backward_unit_top import afb_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_enable,
  input  logic [KIND_W-1:0]        cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     saturated
);

  logic [KIND_W-1:0] kind;
  logic [6:1]        vld;
  logic [7:1]        rdy;
  afb_en_t           en;

  afb_tag_t                 tag1;
  afb_tag_t                 tag2;
  afb_tag_t                 tag3;
  afb_tag_t                 tag4;
  logic signed [DATA_W-1:0] fwd3;
  logic signed [DATA_W-1:0] fwd4;
  logic [DATA_W-1:0]        act4;
  logic                     cmd5;
  logic                     cmd6;
  logic                     out_fwd;
  logic signed [DATA_W-1:0] res6;
  logic                     sat6;
  logic                     in_range;
  logic                     store_wr;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    rdy[7] = !out_valid || out_ready;
    for (int i = 6; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    en.s2    = rdy[2];
    en.s3    = rdy[3];
    en.s4    = rdy[4];
    en.s5    = rdy[5];
    en.s6    = rdy[6];
    en.o     = rdy[7];
    in_ready = rdy[1];
    in_range = {{(IDX_CMP_W-IDX_W){1'b0}}, element_index} < IDX_CMP_W'(MAX_ELEMENTS);
    store_wr = vld[3] && en.s4 && (tag3.cmd == CMD_FORWARD) && tag3.in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      kind      <= KIND_RELU;
    end else begin
      if (cfg_write_enable) begin
        kind <= cfg_write_data;
      end
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= 6; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[7]) begin
        out_valid <= vld[6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      tag1 <= '{cmd: command, in_range: in_range, idx: element_index,
                operand: operand_value};
    end
    if (en.s2) begin
      tag2 <= tag1;
    end
    if (en.s3) begin
      tag3 <= tag2;
    end
    if (en.s4) begin
      tag4 <= tag3;
      fwd4 <= fwd3;
    end
    if (en.s5) begin
      cmd5 <= tag4.cmd;
    end
    if (en.s6) begin
      cmd6 <= cmd5;
    end
    if (en.o) begin
      result_value <= res6;
      saturated    <= sat6;
      out_fwd      <= (cmd6 == CMD_FORWARD);
    end
  end

  afb_fwd u_fwd (
    .clk       (clk),
    .en        (en),
    .kind      (kind),
    .operand1  (tag1.operand),
    .operand3  (tag3.operand),
    .fwd_value (fwd3)
  );

  afb_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .rd_en   (en.s4),
    .addr    (tag3.idx),
    .wr_data (fwd3),
    .rd_data (act4)
  );

  afb_grad u_grad (
    .clk       (clk),
    .en        (en),
    .kind      (kind),
    .cmd4      (tag4.cmd),
    .in_range4 (tag4.in_range),
    .act4      (act4),
    .grad4     (tag4.operand),
    .fwd4      (fwd4),
    .res6      (res6),
    .sat6      (sat6)
  );

  // forward results always fit in Q4.12
  a_fwd_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fwd |-> !saturated)
    else $error("forward result flagged as saturated");

  // an accepted request with no result leaving adds exactly one to occupancy
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !(out_valid && out_ready)
    |=> $countones({vld, out_valid}) == $past($countones({vld, out_valid})) + 1)
    else $error("pipeline occupancy lost or duplicated a request");

  // a result leaving with no new request removes exactly one
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) && out_valid && out_ready
    |=> $countones({vld, out_valid}) == $past($countones({vld, out_valid})) - 1)
    else $error("pipeline drain lost or duplicated a request");

endmodule

FILE: hdl/afb_fwd.sv
// ----------------------------------------------------------------------------
// afb_fwd
// Forward activation datapath: tanh doubling and table lookup, interpolation
// multiply, then the final relu / sigmoid / tanh select.
// ----------------------------------------------------------------------------
module afb_fwd import afb_pkg::*; (
  input  logic                     clk,
  input  afb_en_t                  en,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] operand1,
  input  logic signed [DATA_W-1:0] operand3,
  output logic signed [DATA_W-1:0] fwd_value
);

  logic signed [DATA_W-1:0] dbl;
  logic signed [DATA_W-1:0] x;
  logic [DATA_W-1:0]        u;
  logic [SEG_BITS:0]        seg_ix;
  logic [SEG_BITS:0]        seg_ix_p1;
  logic [ROM_W-1:0]         y_lo;
  logic [ROM_W-1:0]         y_hi;

  logic [ROM_W-1:0]          y0_2;
  logic [ROM_W-1:0]          diff2;
  logic [OFS_BITS-1:0]       ofs2;
  logic [ROM_W-1:0]          y0_3;
  logic [ROM_W+OFS_BITS-1:0] prod3;
  logic [ROM_W-1:0]          sig;

  // stage 1: doubled input for tanh, clamped to the 16-bit range
  always_comb begin
    if (!operand1[DATA_W-1] && operand1[DATA_W-2]) begin
      dbl = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (operand1[DATA_W-1] && !operand1[DATA_W-2]) begin
      dbl = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      dbl = {operand1[DATA_W-2:0], 1'b0};
    end
    x         = (kind == KIND_TANH) ? dbl : operand1;
    u         = {~x[DATA_W-1], x[DATA_W-2:0]};   // offset binary
    seg_ix    = {1'b0, u[DATA_W-1 -: SEG_BITS]};
    seg_ix_p1 = seg_ix + 1'b1;
    y_lo      = SIG_ROM[seg_ix];
    y_hi      = SIG_ROM[seg_ix_p1];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      y0_2  <= y_lo;
      diff2 <= y_hi - y_lo;
      ofs2  <= u[OFS_BITS-1:0];
    end
    if (en.s3) begin
      y0_3  <= y0_2;
      prod3 <= (ROM_W+OFS_BITS)'(diff2) * (ROM_W+OFS_BITS)'(ofs2);
    end
  end

  // stage 3: interpolated sigmoid and kind select
  always_comb begin
    sig = y0_3 + prod3[ROM_W+OFS_BITS-1:OFS_BITS];
    case (kind)
      KIND_SIGMOID: fwd_value = {{(DATA_W-ROM_W){1'b0}}, sig};
      KIND_TANH:    fwd_value = $signed({{(DATA_W-ROM_W-1){1'b0}}, sig, 1'b0})
                                - DATA_W'(ONE);
      default:      fwd_value = operand3[DATA_W-1] ? '0 : operand3;
    endcase
  end

endmodule

FILE: hdl/afb_store.sv
// ----------------------------------------------------------------------------
// afb_store
// Activation store: one write port and one read port on a single shared address, read data registered.
// ----------------------------------------------------------------------------
module afb_store import afb_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = (MAX_ELEMENTS < (1 << IDX_W)) ? MAX_ELEMENTS : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr[AW-1:0]];
    end
  end

endmodule

FILE: hdl/afb_grad.sv
// ----------------------------------------------------------------------------
// afb_grad
// Gradient datapath: derivative product from the stored activation, gradient
// multiply, then floor shift and clip. Forward items pass through times one.
// ----------------------------------------------------------------------------
module afb_grad import afb_pkg::*; (
  input  logic                     clk,
  input  afb_en_t                  en,
  input  logic [KIND_W-1:0]        kind,
  input  logic                     cmd4,
  input  logic                     in_range4,
  input  logic [DATA_W-1:0]        act4,
  input  logic signed [DATA_W-1:0] grad4,
  input  logic signed [DATA_W-1:0] fwd4,
  output logic signed [DATA_W-1:0] res6,
  output logic                     sat6
);

  localparam int SH_W = P2_W - FRAC_BITS;

  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W:0]   m;
  logic signed [P1_W-1:0]   p1;

  logic signed [P1_W-1:0]   p1_5;
  logic signed [DATA_W-1:0] g5;
  logic                     cmd5;
  logic                     apos5;
  logic signed [D_W-1:0]    p1s;
  logic signed [D_W-1:0]    d;
  logic signed [P2_W-1:0]   p2;

  logic signed [P2_W-1:0]   p2_6;
  logic [SH_W-1:0]          sh;
  logic [SH_W-DATA_W:0]     hi;

  // stage 4: a * (one - a) for sigmoid, a * a for tanh
  always_comb begin
    a  = in_range4 ? $signed(act4) : '0;
    m  = (kind == KIND_SIGMOID) ? ((DATA_W+1)'(ONE) - {a[DATA_W-1], a})
                                : {a[DATA_W-1], a};
    p1 = P1_W'(a) * P1_W'(m);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      p1_5  <= p1;
      g5    <= (cmd4 == CMD_BACKWARD) ? grad4 : fwd4;
      cmd5  <= cmd4;
      apos5 <= !a[DATA_W-1] && (|a[DATA_W-2:0]);
    end
  end

  // stage 5: derivative select and gradient multiply
  always_comb begin
    p1s = p1_5[P1_W-1:FRAC_BITS];
    if (cmd5 == CMD_FORWARD) begin
      d = D_W'(ONE);
    end else begin
      case (kind)
        KIND_SIGMOID: d = p1s;
        KIND_TANH:    d = D_W'(ONE) - p1s;
        default:      d = apos5 ? D_W'(ONE) : '0;
      endcase
    end
    p2 = P2_W'(g5) * P2_W'(d);
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      p2_6 <= p2;
    end
  end

  // stage 6: floor shift and clip to 16 bits
  always_comb begin
    sh   = p2_6[P2_W-1:FRAC_BITS];
    hi   = sh[SH_W-1:DATA_W-1];
    sat6 = !((&hi) || !(|hi));
    if (sat6) begin
      res6 = sh[SH_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res6 = sh[DATA_W-1:0];
    end
  end

endmodule
